@@ rtl/core/h2r_pkg.sv @@
`default_nettype none

package h2r_pkg;

  // Port field types
  typedef logic [8:0] hue_t;
  typedef logic [6:0] pct_t;
  typedef logic [7:0] chan_t;

  // Internal widths: every channel term stays within 0..600000
  localparam int unsigned TermW  = 20;
  localparam int unsigned SvW    = 14;
  localparam int unsigned WgtW   = 6;
  localparam int unsigned RecipW = 29;
  localparam int unsigned ProdW  = TermW + RecipW;

  typedef logic [TermW-1:0]  term_t;
  typedef logic [SvW-1:0]    sv_t;
  typedef logic [WgtW-1:0]   wgt_t;
  typedef logic [ProdW-1:0]  prod_t;

  localparam pct_t  PCT_MAX   = 7'd100;
  localparam wgt_t  DEG_60    = 6'd60;
  localparam hue_t  HUE_60    = 9'd60;
  localparam hue_t  HUE_120   = 9'd120;
  localparam hue_t  HUE_180   = 9'd180;
  localparam hue_t  HUE_240   = 9'd240;
  localparam hue_t  HUE_300   = 9'd300;
  localparam hue_t  HUE_360   = 9'd360;
  localparam hue_t  HUE_480   = 9'd480;
  localparam term_t BRI_SCALE = 20'd6000;
  localparam term_t CHR_SCALE = 20'd60;

  // floor(t*255/600000) = floor(t*17/40000) = (t * 17*ceil(2^40/40000)) >> 40,
  // exact for every t in 0..600000
  localparam logic [RecipW-1:0] RECIP_K   = 29'd467292447;
  localparam int unsigned       RecipShift = 40;

  // 60-degree hue sectors
  typedef logic [2:0] sector_t;
  localparam sector_t SEC_RED_YEL = 3'd0;
  localparam sector_t SEC_YEL_GRN = 3'd1;
  localparam sector_t SEC_GRN_CYN = 3'd2;
  localparam sector_t SEC_CYN_BLU = 3'd3;
  localparam sector_t SEC_BLU_MAG = 3'd4;
  localparam sector_t SEC_MAG_RED = 3'd5;

  localparam int unsigned PipeDepth = 5;

endpackage

`default_nettype wire

@@ rtl/core/hsv_to_rgb_pixel.sv @@
// Each transaction accepted at a clock edge passes through the registered
// pipeline stages; its result shows on the out_ ports from the last stage.
// Throughput: one pixel transaction per clock; busy is held low, so start
// may stay high in every cycle. The receiver cannot stall: each result shows
// for exactly one cycle. Synchronous active-low reset clears the valid
// pipeline; transactions in flight at reset are dropped.
`default_nettype none

module hsv_to_rgb_pixel (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  output logic                busy,
  input  wire h2r_pkg::hue_t  in_hue,
  input  wire h2r_pkg::pct_t  in_saturation,
  input  wire h2r_pkg::pct_t  in_brightness,
  output logic                out_valid,
  output h2r_pkg::chan_t      out_red,
  output h2r_pkg::chan_t      out_green,
  output h2r_pkg::chan_t      out_blue
);
  import h2r_pkg::*;

  // Valid bits, one per stage, travel alongside the data
  logic [PipeDepth-1:0] vld_r, vld_nxt;

  // Stage 1: clamp, hue sector and secondary weight (60 - |H mod 120 - 60|)
  pct_t    s1_sat_r, s1_sat_nxt;
  pct_t    s1_bri_r, s1_bri_nxt;
  sector_t s1_sec_r, s1_sec_nxt;
  wgt_t    s1_wgt_r, s1_wgt_nxt;

  // Stage 2: S*V and the brightness term V*6000
  sv_t     s2_sv_r,  s2_sv_nxt;
  term_t   s2_v6k_r, s2_v6k_nxt;
  wgt_t    s2_wgt_r, s2_wgt_nxt;
  sector_t s2_sec_r, s2_sec_nxt;

  // Stage 3: chroma C and secondary X
  term_t   s3_c_r,   s3_c_nxt;
  term_t   s3_x_r,   s3_x_nxt;
  term_t   s3_v6k_r, s3_v6k_nxt;
  sector_t s3_sec_r, s3_sec_nxt;

  // Stage 4: channel totals, each in 0..600000
  term_t   s4_red_r, s4_red_nxt;
  term_t   s4_grn_r, s4_grn_nxt;
  term_t   s4_blu_r, s4_blu_nxt;

  // Stage 5: scale to 8 bits by reciprocal multiplication
  chan_t   s5_red_r, s5_red_nxt;
  chan_t   s5_grn_r, s5_grn_nxt;
  chan_t   s5_blu_r, s5_blu_nxt;

  logic  accept;
  hue_t  hue_mod;
  wgt_t  hue_dev;
  term_t offs;
  prod_t prod_red, prod_grn, prod_blu;

  // Never stalls: a new transaction may enter on every edge
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_comb begin
    vld_nxt = {vld_r[PipeDepth-2:0], accept};
  end

  // Stage 1
  always_comb begin
    s1_sat_nxt = (in_saturation > PCT_MAX) ? PCT_MAX : in_saturation;
    s1_bri_nxt = (in_brightness > PCT_MAX) ? PCT_MAX : in_brightness;

    // Hue 360 and above stays in the last sector
    if (in_hue < HUE_60) begin
      s1_sec_nxt = SEC_RED_YEL;
    end else if (in_hue < HUE_120) begin
      s1_sec_nxt = SEC_YEL_GRN;
    end else if (in_hue < HUE_180) begin
      s1_sec_nxt = SEC_GRN_CYN;
    end else if (in_hue < HUE_240) begin
      s1_sec_nxt = SEC_CYN_BLU;
    end else if (in_hue < HUE_300) begin
      s1_sec_nxt = SEC_BLU_MAG;
    end else begin
      s1_sec_nxt = SEC_MAG_RED;
    end

    // H mod 120 over the full 9-bit range
    if (in_hue < HUE_120) begin
      hue_mod = in_hue;
    end else if (in_hue < HUE_240) begin
      hue_mod = in_hue - HUE_120;
    end else if (in_hue < HUE_360) begin
      hue_mod = in_hue - HUE_240;
    end else if (in_hue < HUE_480) begin
      hue_mod = in_hue - HUE_360;
    end else begin
      hue_mod = in_hue - HUE_480;
    end

    if (hue_mod >= HUE_60) begin
      hue_dev = WgtW'(hue_mod - HUE_60);
    end else begin
      hue_dev = WgtW'(HUE_60 - hue_mod);
    end
    s1_wgt_nxt = DEG_60 - hue_dev;
  end

  // Stage 2
  always_comb begin
    s2_sv_nxt  = SvW'(s1_sat_r) * SvW'(s1_bri_r);
    s2_v6k_nxt = TermW'(s1_bri_r) * BRI_SCALE;
    s2_wgt_nxt = s1_wgt_r;
    s2_sec_nxt = s1_sec_r;
  end

  // Stage 3
  always_comb begin
    s3_c_nxt   = TermW'(s2_sv_r) * CHR_SCALE;
    s3_x_nxt   = TermW'(s2_sv_r) * TermW'(s2_wgt_r);
    s3_v6k_nxt = s2_v6k_r;
    s3_sec_nxt = s2_sec_r;
  end

  // Stage 4: place C, X and 0 by sector, then add the offset m = V*6000 - C
  always_comb begin
    offs       = s3_v6k_r - s3_c_r;
    s4_red_nxt = offs;
    s4_grn_nxt = offs;
    s4_blu_nxt = offs;
    case (s3_sec_r)
      SEC_RED_YEL: begin
        s4_red_nxt = s3_c_r + offs;
        s4_grn_nxt = s3_x_r + offs;
      end
      SEC_YEL_GRN: begin
        s4_red_nxt = s3_x_r + offs;
        s4_grn_nxt = s3_c_r + offs;
      end
      SEC_GRN_CYN: begin
        s4_grn_nxt = s3_c_r + offs;
        s4_blu_nxt = s3_x_r + offs;
      end
      SEC_CYN_BLU: begin
        s4_grn_nxt = s3_x_r + offs;
        s4_blu_nxt = s3_c_r + offs;
      end
      SEC_BLU_MAG: begin
        s4_red_nxt = s3_x_r + offs;
        s4_blu_nxt = s3_c_r + offs;
      end
      default: begin
        s4_red_nxt = s3_c_r + offs;
        s4_blu_nxt = s3_x_r + offs;
      end
    endcase
  end

  // Stage 5: keep bits above the reciprocal shift; the quotient never exceeds 255
  always_comb begin
    prod_red   = ProdW'(s4_red_r) * ProdW'(RECIP_K);
    prod_grn   = ProdW'(s4_grn_r) * ProdW'(RECIP_K);
    prod_blu   = ProdW'(s4_blu_r) * ProdW'(RECIP_K);
    s5_red_nxt = prod_red[RecipShift +: 8];
    s5_grn_nxt = prod_grn[RecipShift +: 8];
    s5_blu_nxt = prod_blu[RecipShift +: 8];
  end

  // Control state: cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Payload: advance every cycle, no reset needed
  always_ff @(posedge clk) begin
    s1_sat_r <= s1_sat_nxt;
    s1_bri_r <= s1_bri_nxt;
    s1_sec_r <= s1_sec_nxt;
    s1_wgt_r <= s1_wgt_nxt;
    s2_sv_r  <= s2_sv_nxt;
    s2_v6k_r <= s2_v6k_nxt;
    s2_wgt_r <= s2_wgt_nxt;
    s2_sec_r <= s2_sec_nxt;
    s3_c_r   <= s3_c_nxt;
    s3_x_r   <= s3_x_nxt;
    s3_v6k_r <= s3_v6k_nxt;
    s3_sec_r <= s3_sec_nxt;
    s4_red_r <= s4_red_nxt;
    s4_grn_r <= s4_grn_nxt;
    s4_blu_r <= s4_blu_nxt;
    s5_red_r <= s5_red_nxt;
    s5_grn_r <= s5_grn_nxt;
    s5_blu_r <= s5_blu_nxt;
  end

  assign out_valid = vld_r[PipeDepth-1];
  assign out_red   = s5_red_r;
  assign out_green = s5_grn_r;
  assign out_blue  = s5_blu_r;

endmodule

`default_nettype wire

@@ rtl/core/h2r_chk.sv @@
`default_nettype none

module h2r_chk (
  input wire                clk,
  input wire                rst_n,
  input wire                start,
  input wire                busy,
  input wire h2r_pkg::hue_t in_hue,
  input wire h2r_pkg::pct_t in_saturation,
  input wire h2r_pkg::pct_t in_brightness,
  input wire                out_valid,
  input wire h2r_pkg::chan_t out_red,
  input wire h2r_pkg::chan_t out_green,
  input wire h2r_pkg::chan_t out_blue
);
  import h2r_pkg::*;

  // Every accepted transaction produces a result with out_valid set
  a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##5 out_valid)
    else $error("accepted transaction produced no result");

  // No result without a matching accepted transaction
  a_lat_back: assert property (@(posedge clk)
    out_valid |-> $past(start && !busy, 5))
    else $error("result without a matching transaction");

  // Sync reset drains the pipeline
  a_rst_clr: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result straight after reset");

  // Zero saturation gives grey
  a_grey: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_saturation == '0) |->
      ##5 (out_red == out_green && out_green == out_blue))
    else $error("zero saturation did not give grey");

  // Zero brightness gives black, whatever the hue
  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_brightness == '0) |->
      ##5 (out_red == '0 && out_green == '0 && out_blue == '0))
    else $error("zero brightness did not give black");

endmodule

bind hsv_to_rgb_pixel h2r_chk u_h2r_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_hue        (in_hue),
  .in_saturation (in_saturation),
  .in_brightness (in_brightness),
  .out_valid     (out_valid),
  .out_red       (out_red),
  .out_green     (out_green),
  .out_blue      (out_blue)
);

`default_nettype wire
